@@ design/lsdd_pkg.sv @@
// ----------------------------------------------------------------------------
// lsdd_pkg
// Shared types, register indexes, reset values and the ladder quantizer for
// the ladder switch decoder with debounce.
// ----------------------------------------------------------------------------
package lsdd_pkg;

    localparam int NUM_SWITCHES   = 3;
    localparam int NUM_THRESHOLDS = 7;
    localparam int SAMPLE_W       = 12;
    localparam int MASK_W         = 8;
    localparam int LEVEL_W        = 3;
    localparam int REG_IDX_W      = 3;
    localparam int APB_ADDR_W     = REG_IDX_W + 2;
    localparam int APB_DATA_W     = 32;

    typedef logic [SAMPLE_W-1:0]     sample_t;
    typedef logic [NUM_SWITCHES-1:0] switch_vec_t;
    typedef logic [LEVEL_W-1:0]      level_t;
    typedef logic [MASK_W-1:0]       mask_t;
    typedef sample_t [NUM_THRESHOLDS-1:0] thresh_array_t;

    // register map, one word per register
    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESH_1,
        REG_THRESH_2,
        REG_THRESH_3,
        REG_THRESH_4,
        REG_THRESH_5,
        REG_THRESH_6,
        REG_THRESH_7,
        REG_AGREE_MASK
    } reg_idx_t;

    // configuration seen by the datapath
    typedef struct packed {
        thresh_array_t thresholds;
        mask_t         agree_mask;
    } cfg_t;

    // one result transaction
    typedef struct packed {
        switch_vec_t settled;
        switch_vec_t rise;
        switch_vec_t fall;
    } result_t;

    localparam thresh_array_t THRESH_RESET = {
        12'd3583, 12'd3071, 12'd2559, 12'd2047, 12'd1535, 12'd1023, 12'd511
    };
    localparam mask_t AGREE_MASK_RESET = 8'd7;

    // first threshold at or above the sample wins, level 7 if none
    function automatic level_t quantize(input sample_t s, input thresh_array_t th);
        level_t lvl;
        lvl = level_t'(NUM_THRESHOLDS);
        for (int n = NUM_THRESHOLDS - 1; n >= 0; n--)
        begin
            if (s <= th[n])
            begin
                lvl = level_t'(n);
            end
        end
        return lvl;
    endfunction

endpackage

@@ design/lsdd_channels.sv @@
// ----------------------------------------------------------------------------
// lsdd channels
// Valid/ready stream interfaces for ADC sample and switch result transactions.
// ----------------------------------------------------------------------------
interface lsdd_sample_if;
    logic              valid;
    logic              ready;
    lsdd_pkg::sample_t adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface lsdd_result_if;
    logic                  valid;
    logic                  ready;
    lsdd_pkg::switch_vec_t settled_levels;
    lsdd_pkg::switch_vec_t rising_edges;
    lsdd_pkg::switch_vec_t falling_edges;

    modport source (output valid, output settled_levels, output rising_edges,
                    output falling_edges, input ready);
    modport sink   (input valid, input settled_levels, input rising_edges,
                    input falling_edges, output ready);
endinterface

@@ design/ladder_switch_decoder_debounce_unit.sv @@
// ----------------------------------------------------------------------------
// ladder_switch_decoder_debounce_unit
// Resistor ladder decoder for three switches with masked-history debounce.
// ----------------------------------------------------------------------------
// Each accepted ADC sample transaction yields exactly one result transaction.
// The sample is registered, then quantized against seven thresholds to a
// 3-bit level whose bits are the raw switch readings; each switch shifts its
// bit into a HISTORY_BITS history and settles off when the masked history is
// all zeros, on when it equals the mask. The unit takes one sample per cycle
// while the result side does not stall; the sample waits in the input
// register until the result register is free, then its result is loaded
// into the result register; the result register is the only stage
// that stalls on the result side, so the sample side keeps flowing as long
// as that register is free or being emptied. Thresholds and the agree mask
// sit in an APB register file and should be written only while idle.
// ----------------------------------------------------------------------------
module ladder_switch_decoder_debounce_unit #(
    parameter int HISTORY_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    lsdd_sample_if.sink                         sample,
    lsdd_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsdd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lsdd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lsdd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    lsdd_pkg::cfg_t     cfg;
    logic               in_valid_reg;
    lsdd_pkg::sample_t  sample_reg;
    logic               res_valid_reg;
    lsdd_pkg::result_t  res_reg;
    lsdd_pkg::result_t  res_next;
    lsdd_pkg::level_t   level;
    logic               res_free;
    logic               step_en;

    // configuration registers
    lsdd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline flow control
    assign res_free     = !res_valid_reg || result.ready;
    assign step_en      = in_valid_reg && res_free;
    assign sample.ready = !in_valid_reg || res_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            sample_reg <= sample.adc_sample;
        end
    end

    // quantize and debounce
    assign level = lsdd_pkg::quantize(sample_reg, cfg.thresholds);

    lsdd_debounce #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_debounce (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .level      (level),
        .agree_mask (cfg.agree_mask),
        .res_next   (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.settled_levels = res_reg.settled;
    assign result.rising_edges   = res_reg.rise;
    assign result.falling_edges  = res_reg.fall;

endmodule

@@ design/lsdd_apb_regs.sv @@
// ----------------------------------------------------------------------------
// lsdd_apb_regs
// APB register file holding the seven ladder thresholds and the agree mask.
// ----------------------------------------------------------------------------
module lsdd_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lsdd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lsdd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lsdd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output lsdd_pkg::cfg_t                      cfg
);

    lsdd_pkg::cfg_t   cfg_reg;
    lsdd_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = lsdd_pkg::reg_idx_t'(paddr[lsdd_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresholds <= lsdd_pkg::THRESH_RESET;
            cfg_reg.agree_mask <= lsdd_pkg::AGREE_MASK_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                lsdd_pkg::REG_AGREE_MASK:
                    cfg_reg.agree_mask <= pwdata[lsdd_pkg::MASK_W-1:0];
                default:
                    cfg_reg.thresholds[idx] <= pwdata[lsdd_pkg::SAMPLE_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            lsdd_pkg::REG_AGREE_MASK:
                prdata = {{(lsdd_pkg::APB_DATA_W-lsdd_pkg::MASK_W){1'b0}},
                          cfg_reg.agree_mask};
            default:
                prdata = {{(lsdd_pkg::APB_DATA_W-lsdd_pkg::SAMPLE_W){1'b0}},
                          cfg_reg.thresholds[idx]};
        endcase
    end

endmodule

@@ design/lsdd_debounce.sv @@
// ----------------------------------------------------------------------------
// lsdd_debounce
// Per-switch history shift registers and settled state; computes the next
// settled levels and edge flags for one level sample.
// ----------------------------------------------------------------------------
module lsdd_debounce #(
    parameter int HISTORY_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  lsdd_pkg::level_t     level,
    input  lsdd_pkg::mask_t      agree_mask,
    output lsdd_pkg::result_t    res_next
);

    logic [HISTORY_BITS-1:0] hist_reg  [lsdd_pkg::NUM_SWITCHES];
    logic [HISTORY_BITS-1:0] hist_next [lsdd_pkg::NUM_SWITCHES];
    logic [HISTORY_BITS-1:0] mask_eff;
    lsdd_pkg::switch_vec_t   settled_reg;
    lsdd_pkg::switch_vec_t   settled_next;

    // mask bits beyond the history width are dropped, missing ones are zero
    for (genvar b = 0; b < HISTORY_BITS; b++)
    begin : g_mask
        if (b < lsdd_pkg::MASK_W)
        begin : g_in
            assign mask_eff[b] = agree_mask[b];
        end
        else
        begin : g_out
            assign mask_eff[b] = 1'b0;
        end
    end

    // per switch: shift in raw bit, settle on full agreement
    for (genvar i = 0; i < lsdd_pkg::NUM_SWITCHES; i++)
    begin : g_sw
        logic [HISTORY_BITS-1:0] work;

        assign hist_next[i] = {hist_reg[i][HISTORY_BITS-2:0], level[i]};
        assign work         = hist_next[i] & mask_eff;

        // all zeros settles off first, full agreement settles on, else hold
        assign settled_next[i] = (work == '0)       ? 1'b0 :
                                 (work == mask_eff) ? 1'b1 :
                                                      settled_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hist_reg[i] <= '0;
            end
            else if (step_en)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    // settled state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settled_reg <= '0;
        end
        else if (step_en)
        begin
            settled_reg <= settled_next;
        end
    end

    assign res_next.settled = settled_next;
    assign res_next.rise    = settled_next & ~settled_reg;
    assign res_next.fall    = ~settled_next & settled_reg;

endmodule

@@ design/lsdd_checker.sv @@
// ----------------------------------------------------------------------------
// lsdd_port_checker
// Port-level assertions for the ladder switch decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lsdd_port_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_ready,
    input lsdd_pkg::switch_vec_t settled,
    input lsdd_pkg::switch_vec_t rise,
    input lsdd_pkg::switch_vec_t fall
);

    lsdd_pkg::switch_vec_t last_settled_reg;

    // settled levels of the last delivered result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_settled_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            last_settled_reg <= settled;
        end
    end

    // edges must match the change from the previous result
    a_edges_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (rise == (settled & ~last_settled_reg)) &&
                      (fall == (~settled & last_settled_reg)))
        else $error("edge flags disagree with settled level change");

    // a switch cannot rise and fall in the same transaction
    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((rise & fall) == '0))
        else $error("rising and falling edge on the same switch");

    // no result during reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(settled) &&
                                    $stable(rise) && $stable(fall))
        else $error("stalled result changed");

endmodule

bind ladder_switch_decoder_debounce_unit lsdd_port_checker u_lsdd_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .settled   (result.settled_levels),
    .rise      (result.rising_edges),
    .fall      (result.falling_edges)
);
